/* rtl/cbz_pkg.sv */
// Shared widths, constants and register codes of the cubic Bezier evaluator.
package cbz_pkg;

  // Curve parameter, Q1.16 signed on the port, 0..1.0 after clamping
  localparam int unsigned ParamW = 18;
  localparam int unsigned TW     = 17;
  localparam logic [TW-1:0] TOne = 17'd65536;

  // Coordinates: signed Q11.4, three per control point register
  localparam int unsigned CoordW = 16;
  localparam int unsigned CpW    = 3 * CoordW;
  localparam int unsigned NumCp  = 4;
  localparam int unsigned SlopeW = 19;

  // Configuration port
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CP_IDX_0 = 3'd0,
    CP_IDX_1 = 3'd1,
    CP_IDX_2 = 3'd2,
    CP_IDX_3 = 3'd3
  } cp_idx_e;

  // Rounding offsets: point weights scaled by 2^48, slope weights by 2^32
  localparam logic signed [63:0] PtRnd    = 64'sh0000_8000_0000_0000;
  localparam logic signed [52:0] SlopeRnd = 53'sd2147483648;

endpackage

/* rtl/cubic_bezier_point_and_tangent_core.sv */
// Cubic Bezier point and first derivative evaluator, six-stage pipeline.
//
// One item (a curve parameter t, Q1.16) enters per clock unless the pipeline stalls, and
// its result (point and derivative in x, y, z) comes from the output register. Throughput
// is one item per cycle because every step has its own register stage: clamp of t,
// squares and slope weights, Bernstein weights, weight-by-coordinate products (point
// weights split at bit 24), per-axis sums, and the final rounded add into the output
// register. Each stage holds its own valid bit and only stalls when the stage after it
// is full, so bubbles collapse and the input keeps taking items while a result waits at
// the output, until all six stages hold an item. t is clamped to 0..1 before use.
// Control points are written through the configuration port at indexes 0..3 (x in bits
// 15:0, y in 31:16, z in 47:32); writes take effect at once and should be made while no
// item is in flight.
module cubic_bezier_point_and_tangent_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cbz_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [cbz_pkg::CpW-1:0]              cfg_data_i,
  // input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [cbz_pkg::ParamW-1:0]    curve_param_i,
  // result item channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cbz_pkg::CoordW-1:0]    point_x_o,
  output logic signed [cbz_pkg::CoordW-1:0]    point_y_o,
  output logic signed [cbz_pkg::CoordW-1:0]    point_z_o,
  output logic signed [cbz_pkg::SlopeW-1:0]    slope_x_o,
  output logic signed [cbz_pkg::SlopeW-1:0]    slope_y_o,
  output logic signed [cbz_pkg::SlopeW-1:0]    slope_z_o
);

  // Control point registers
  logic [cbz_pkg::CpW-1:0] cp_q [cbz_pkg::NumCp];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cbz_pkg::NumCp; k++) begin
        cp_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cbz_pkg::cp_idx_e'(cfg_index_i))
        cbz_pkg::CP_IDX_0: cp_q[0] <= cfg_data_i;
        cbz_pkg::CP_IDX_1: cp_q[1] <= cfg_data_i;
        cbz_pkg::CP_IDX_2: cp_q[2] <= cfg_data_i;
        cbz_pkg::CP_IDX_3: cp_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coordinates and neighbor differences, [axis][point]
  logic signed [cbz_pkg::CoordW-1:0] coord [3][cbz_pkg::NumCp];
  logic signed [cbz_pkg::CoordW:0]   diff  [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < cbz_pkg::NumCp; k++) begin
        coord[a][k] = $signed(cp_q[k][cbz_pkg::CoordW*a +: cbz_pkg::CoordW]);
      end
      for (int k = 0; k < 3; k++) begin
        diff[a][k] = $signed({coord[a][k+1][cbz_pkg::CoordW-1], coord[a][k+1]})
                   - $signed({coord[a][k][cbz_pkg::CoordW-1], coord[a][k]});
      end
    end
  end

  // Handshake: each stage takes new data when it is empty or its successor moves
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign s5_rdy     = !s5_v_q || out_rdy;
  assign s4_rdy     = !s4_v_q || s5_rdy;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_valid_i;
      if (s2_rdy)  s2_v_q  <= s1_v_q;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (s4_rdy)  s4_v_q  <= s3_v_q;
      if (s5_rdy)  s5_v_q  <= s4_v_q;
      if (out_rdy) out_v_q <= s5_v_q;
    end
  end

  // Stage 1: clamp t to 0..1, form u = 1 - t and the tripled values
  logic [cbz_pkg::TW-1:0] t_d, u_d;
  logic [cbz_pkg::TW:0]   t3_d, u3_d;
  logic [cbz_pkg::TW-1:0] s1_t_q, s1_u_q;
  logic [cbz_pkg::TW:0]   s1_t3_q, s1_u3_q;

  always_comb begin
    if (curve_param_i[cbz_pkg::ParamW-1]) begin
      t_d = '0;
    end else if (curve_param_i[cbz_pkg::TW-1:0] > cbz_pkg::TOne) begin
      t_d = cbz_pkg::TOne;
    end else begin
      t_d = curve_param_i[cbz_pkg::TW-1:0];
    end
    u_d  = cbz_pkg::TOne - t_d;
    t3_d = {t_d, 1'b0} + {1'b0, t_d};
    u3_d = {u_d, 1'b0} + {1'b0, u_d};
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_t_q  <= t_d;
      s1_u_q  <= u_d;
      s1_t3_q <= t3_d;
      s1_u3_q <= u3_d;
    end
  end

  // Stage 2: squares and the slope weights 3u^2, 6ut, 3t^2 (scaled by 2^32)
  logic [cbz_pkg::TW-1:0] s2_t_q, s2_u_q;
  logic [cbz_pkg::TW:0]   s2_t3_q, s2_u3_q;
  logic [32:0]            s2_tt_q, s2_uu_q;
  logic [33:0]            s2_dw_q [3];

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_t_q     <= s1_t_q;
      s2_u_q     <= s1_u_q;
      s2_t3_q    <= s1_t3_q;
      s2_u3_q    <= s1_u3_q;
      s2_tt_q    <= 33'(s1_t_q * s1_t_q);
      s2_uu_q    <= 33'(s1_u_q * s1_u_q);
      s2_dw_q[0] <= 34'(s1_u_q * s1_u3_q);
      s2_dw_q[1] <= {33'(s1_u_q * s1_t3_q), 1'b0};
      s2_dw_q[2] <= 34'(s1_t_q * s1_t3_q);
    end
  end

  // Stage 3: point weights u^3, 3u^2t, 3ut^2, t^3 (scaled by 2^48)
  logic [48:0] s3_wp_q [cbz_pkg::NumCp];
  logic [33:0] s3_dw_q [3];

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_wp_q[0] <= 49'(s2_uu_q * s2_u_q);
      s3_wp_q[1] <= 49'(s2_uu_q * s2_t3_q);
      s3_wp_q[2] <= 49'(s2_tt_q * s2_u3_q);
      s3_wp_q[3] <= 49'(s2_tt_q * s2_t_q);
      for (int k = 0; k < 3; k++) begin
        s3_dw_q[k] <= s2_dw_q[k];
      end
    end
  end

  // Stage 4: weight-by-coordinate products, point weights split at bit 24
  logic signed [40:0] s4_pl_q [3][cbz_pkg::NumCp];
  logic signed [41:0] s4_ph_q [3][cbz_pkg::NumCp];
  logic signed [51:0] s4_pd_q [3][3];

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_v_q) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < cbz_pkg::NumCp; k++) begin
          s4_pl_q[a][k] <= $signed({1'b0, s3_wp_q[k][23:0]}) * coord[a][k];
          s4_ph_q[a][k] <= $signed({1'b0, s3_wp_q[k][48:24]}) * coord[a][k];
        end
        for (int k = 0; k < 3; k++) begin
          s4_pd_q[a][k] <= $signed({1'b0, s3_dw_q[k]}) * diff[a][k];
        end
      end
    end
  end

  // Stage 5: per-axis sums of the low halves, high halves and rounded slope terms
  logic signed [43:0] s5_lsum_q [3];
  logic signed [43:0] s5_hsum_q [3];
  logic signed [52:0] s5_dsum_q [3];

  always_ff @(posedge clk_i) begin
    if (s5_rdy && s4_v_q) begin
      for (int a = 0; a < 3; a++) begin
        s5_lsum_q[a] <= 44'(s4_pl_q[a][0]) + 44'(s4_pl_q[a][1])
                      + 44'(s4_pl_q[a][2]) + 44'(s4_pl_q[a][3]);
        s5_hsum_q[a] <= 44'(s4_ph_q[a][0]) + 44'(s4_ph_q[a][1])
                      + 44'(s4_ph_q[a][2]) + 44'(s4_ph_q[a][3]);
        s5_dsum_q[a] <= 53'(s4_pd_q[a][0]) + 53'(s4_pd_q[a][1])
                      + 53'(s4_pd_q[a][2]) + cbz_pkg::SlopeRnd;
      end
    end
  end

  // Output stage: join and round the point halves, keep the integer parts
  logic signed [63:0]                 ptot [3];
  logic signed [cbz_pkg::CoordW-1:0] pt_q [3];
  logic signed [cbz_pkg::SlopeW-1:0] sl_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ptot[a] = (64'(s5_hsum_q[a]) <<< 24) + 64'(s5_lsum_q[a]) + cbz_pkg::PtRnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s5_v_q) begin
      for (int a = 0; a < 3; a++) begin
        pt_q[a] <= ptot[a][63:48];
        sl_q[a] <= s5_dsum_q[a][50:32];
      end
    end
  end

  assign point_x_o = pt_q[0];
  assign point_y_o = pt_q[1];
  assign point_z_o = pt_q[2];
  assign slope_x_o = sl_q[0];
  assign slope_y_o = sl_q[1];
  assign slope_z_o = sl_q[2];

endmodule

/* rtl/cbz_checker.sv */
// Port-level checks for the cubic Bezier evaluator, bound to its top level.
module cbz_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cbz_pkg::CoordW-1:0] point_x_o,
  input logic signed [cbz_pkg::CoordW-1:0] point_y_o,
  input logic signed [cbz_pkg::CoordW-1:0] point_z_o,
  input logic signed [cbz_pkg::SlopeW-1:0] slope_x_o,
  input logic signed [cbz_pkg::SlopeW-1:0] slope_y_o,
  input logic signed [cbz_pkg::SlopeW-1:0] slope_z_o
);

  // A stalled result item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o) &&
      $stable(point_y_o) && $stable(point_z_o) && $stable(slope_x_o) &&
      $stable(slope_y_o) && $stable(slope_z_o))
    else $error("result item changed while stalled");

  // Derivative never exceeds three times the largest control point span
  a_slope_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slope_x_o >= -32'sd196605 && slope_x_o <= 32'sd196605 &&
      slope_y_o >= -32'sd196605 && slope_y_o <= 32'sd196605 &&
      slope_z_o >= -32'sd196605 && slope_z_o <= 32'sd196605)
    else $error("slope out of range");

  // Nothing is offered while reset is held
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind cubic_bezier_point_and_tangent_core cbz_checker u_cbz_checker (.*);
